// ----- rtl/core/ulr_pkg.sv -----
`timescale 1ns / 1ps

package ulr_pkg;

  // Field widths
  localparam int unsigned RANGE_W   = 16;  // range in cm, also divider dividend
  localparam int unsigned DIVR_W    = 8;   // divisor and remainder
  localparam int unsigned TRIG_W    = 8;   // trigger length register
  localparam int unsigned MAXC_W    = 16;  // out-of-range limit register
  localparam int unsigned HUND_W    = 10;  // hundreds field
  localparam int unsigned DIGIT_W   = 4;   // tens and ones fields
  localparam int unsigned CFG_W     = 16;  // widest register
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM  = 2'd2;

  // Register reset values
  localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd11;
  localparam logic [MAXC_W-1:0] MAX_COUNT_RST     = 16'd38000;
  localparam logic [DIVR_W-1:0] TICKS_PER_CM_RST  = 8'd59;

  // Decimal base for digit extraction
  localparam logic [DIVR_W-1:0] DEC_BASE = 8'd10;

  typedef struct packed {
    logic               start;
    logic [RANGE_W-1:0] dividend;
    logic [DIVR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [RANGE_W-1:0] quotient;
    logic [DIVR_W-1:0]  remainder;
  } div_rsp_t;

endpackage

// ----- rtl/core/ulr_sdiv.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle through a shift register.
module ulr_sdiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ulr_pkg::div_req_t req_i,
  output ulr_pkg::div_rsp_t rsp_o
);
  import ulr_pkg::*;

  localparam int unsigned CNT_W = $clog2(RANGE_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RANGE_W - 1);

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [RANGE_W-1:0] quo_q;
  logic [DIVR_W-1:0]  rem_q, div_q;
  logic [DIVR_W:0]    trial, diff;
  logic               ge;

  // Trial subtract of the next dividend bit
  always_comb begin
    trial = {rem_q, quo_q[RANGE_W-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Shift quotient bits in, keep partial remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[RANGE_W-2:0], ge};
      rem_q <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- rtl/core/ultrasonic_echo_ranger.sv -----
`timescale 1ns / 1ps

// Ultrasonic echo ranger. Every transfer on the input stream is one timer tick with
// the sampled echo level, and every tick yields exactly one output transfer. The block
// drives trigger for trigger_ticks ticks, waits for echo, counts ticks while echo is high
// (saturating at 2^COUNT_WIDTH-1) and reports distance = count / ticks_per_cm plus its
// hundreds, tens and ones digits on the tick where echo falls; a count at or above
// max_count reports range 0 with out_of_range set. Ordinary ticks and out-of-range
// readings are offered in the cycle after their input transfer. An in-range reading is
// offered once one shared bit-serial divider has run three passes of 16 steps each
// (count by ticks_per_cm, then twice by ten for the digits), and no new tick is taken
// meanwhile. A finished result sits in an output register, and a tick is taken only when
// it is empty or read. Write registers only while idle; the block does not enforce it.
module ultrasonic_echo_ranger #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [ulr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ulr_pkg::CFG_W-1:0]     cfg_wdata_i,
  // tick stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [0] echo_level, [7:1] zero
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] trigger_out, [16:1] range_cm, [17] out_of_range, [27:18] digit_hundreds,
  // [31:28] digit_tens, [35:32] digit_ones, [39:36] zero
  output logic [39:0]                   m_axis_tdata,
  output logic                          m_axis_tuser   // [0] reading_valid
);
  import ulr_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > MAXC_W) ? COUNT_WIDTH : MAXC_W;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_COUNT   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_TENS  = 2'd2,
    ST_HUND  = 2'd3
  } state_e;

  // Configuration registers
  logic [TRIG_W-1:0] trig_ticks_q;
  logic [MAXC_W-1:0] max_count_q;
  logic [DIVR_W-1:0] ticks_cm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= TRIGGER_TICKS_RST;
      max_count_q  <= MAX_COUNT_RST;
      ticks_cm_q   <= TICKS_PER_CM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRIGGER_TICKS: trig_ticks_q <= cfg_wdata_i[TRIG_W-1:0];
        CFG_MAX_COUNT:     max_count_q  <= cfg_wdata_i[MAXC_W-1:0];
        CFG_TICKS_PER_CM:  ticks_cm_q   <= cfg_wdata_i[DIVR_W-1:0];
        default: ;
      endcase
    end
  end

  // Measurement state and sequencer
  phase_e                 phase_q, phase_d;
  state_e                 st_q;
  logic [TRIG_W-1:0]      tcnt_q, tcnt_d, tcnt_inc, trig_len;
  logic [COUNT_WIDTH-1:0] ecnt_q, ecnt_d;
  logic                   echo, accept, trig, reading, oor, need_div;

  // Output register
  logic                   m_valid_q, m_valid_d, m_user_q, m_trig_q, m_oor_q;
  logic [RANGE_W-1:0]     m_range_q, range_q;
  logic [HUND_W-1:0]      m_hund_q;
  logic [DIGIT_W-1:0]     m_tens_q, m_ones_q, ones_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign echo          = s_axis_tdata[0];
  assign s_axis_tready = (st_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Next measurement state for one tick
  always_comb begin
    phase_d  = phase_q;
    tcnt_d   = tcnt_q;
    ecnt_d   = ecnt_q;
    trig     = 1'b0;
    reading  = 1'b0;
    oor      = CMP_W'(ecnt_q) >= CMP_W'(max_count_q);
    tcnt_inc = tcnt_q + 1'b1;
    trig_len = (trig_ticks_q == '0) ? TRIG_W'(1) : trig_ticks_q;
    case (phase_q)
      PH_WAIT: begin
        if (echo) begin
          phase_d = PH_COUNT;
          ecnt_d  = COUNT_WIDTH'(1);
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (ecnt_q != '1) ecnt_d = ecnt_q + 1'b1;
        end else begin
          reading = 1'b1;
          phase_d = PH_TRIGGER;
          tcnt_d  = '0;
          ecnt_d  = '0;
        end
      end
      default: begin
        trig = 1'b1;
        if (tcnt_inc >= trig_len) begin
          tcnt_d  = '0;
          phase_d = PH_WAIT;
        end else begin
          tcnt_d = tcnt_inc;
        end
      end
    endcase
    need_div = reading && !oor;
  end

  // Divider requests: first pass on the tick, then chained digit passes
  always_comb begin
    div_req.start    = (accept && need_div) ||
                       (div_rsp.done && ((st_q == ST_RANGE) || (st_q == ST_TENS)));
    div_req.dividend = (st_q == ST_IDLE) ? RANGE_W'(ecnt_q) : div_rsp.quotient;
    div_req.divisor  = (st_q != ST_IDLE) ? DEC_BASE :
                       ((ticks_cm_q == '0) ? DIVR_W'(1) : ticks_cm_q);
  end

  ulr_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Drop the result on its transfer, raise it when a new one is loaded
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    if (((st_q == ST_IDLE) && accept && !need_div) ||
        ((st_q == ST_HUND) && div_rsp.done)) begin
      m_valid_d = 1'b1;
    end
  end

  // Hold state, sequence the divider passes, load the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TRIGGER;
      tcnt_q    <= '0;
      ecnt_q    <= '0;
      st_q      <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      case (st_q)
        ST_IDLE: begin
          if (accept) begin
            phase_q <= phase_d;
            tcnt_q  <= tcnt_d;
            ecnt_q  <= ecnt_d;
            if (need_div) begin
              st_q <= ST_RANGE;
            end
          end
        end
        ST_RANGE: if (div_rsp.done) st_q <= ST_TENS;
        ST_TENS:  if (div_rsp.done) st_q <= ST_HUND;
        default: begin
          if (div_rsp.done) begin
            st_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Output payload and intermediate digits
  always_ff @(posedge clk_i) begin
    if (accept && !need_div) begin
      m_trig_q  <= trig;
      m_user_q  <= reading;
      m_oor_q   <= reading;
      m_range_q <= '0;
      m_hund_q  <= '0;
      m_tens_q  <= '0;
      m_ones_q  <= '0;
    end
    if (div_rsp.done) begin
      case (st_q)
        ST_RANGE: range_q <= div_rsp.quotient;
        ST_TENS:  ones_q  <= div_rsp.remainder[DIGIT_W-1:0];
        ST_HUND: begin
          m_trig_q  <= 1'b0;
          m_user_q  <= 1'b1;
          m_oor_q   <= 1'b0;
          m_range_q <= range_q;
          m_hund_q  <= div_rsp.quotient[HUND_W-1:0];
          m_tens_q  <= div_rsp.remainder[DIGIT_W-1:0];
          m_ones_q  <= ones_q;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = {4'b0, m_ones_q, m_tens_q, m_hund_q, m_oor_q, m_range_q, m_trig_q};

  // Divider never runs while ticks are being taken
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted mid-pass");

  a_last_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_rsp.done && (st_q == ST_HUND)) |=> m_valid_q)
    else $error("final divider pass did not load the result");

  a_trig_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(m_trig_q && m_user_q))
    else $error("trigger and reading on the same tick");

  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_user_q) |-> ((m_tens_q < 4'd10) && (m_ones_q < 4'd10)))
    else $error("decimal digit out of range");

  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_COUNT) |-> (ecnt_q != '0))
    else $error("echo count zero while counting");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ulr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 80;   // beyond the longest in-range reading
  localparam int unsigned SEG_TICKS    = 200;  // minimum ticks per random segment
  localparam logic [15:0] COUNT_SAT    = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_COUNT   = 2'd2
  } ranger_phase_e;

  typedef struct packed {
    logic                 trig;
    logic                 valid;
    logic [RANGE_W-1:0]   range_cm;
    logic                 oor;
    logic [HUND_W-1:0]    hund;
    logic [DIGIT_W-1:0]   tens;
    logic [DIGIT_W-1:0]   ones;
    logic [3:0]           pad;
  } tick_result_t;

  // Predicts one result per tick and matches it against the output stream
  class range_scoreboard;
    logic [TRIG_W-1:0]  trig_len;
    logic [MAXC_W-1:0]  limit;
    logic [DIVR_W-1:0]  cm_div;
    ranger_phase_e      phase;
    logic [7:0]         trig_cnt;
    logic [15:0]        echo_cnt;
    tick_result_t       pending_q[$];
    int unsigned        errors;
    int unsigned        ticks;
    int unsigned        readings;
    int unsigned        oor_readings;
    int unsigned        settings;

    function new();
      trig_len     = TRIGGER_TICKS_RST;
      limit        = MAX_COUNT_RST;
      cm_div       = TICKS_PER_CM_RST;
      phase        = PH_TRIGGER;
      trig_cnt     = '0;
      echo_cnt     = '0;
      errors       = 0;
      ticks        = 0;
      readings     = 0;
      oor_readings = 0;
      settings     = 1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_TRIGGER_TICKS: trig_len = val[TRIG_W-1:0];
        CFG_MAX_COUNT:     limit    = val[MAXC_W-1:0];
        CFG_TICKS_PER_CM:  cm_div   = val[DIVR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned trigger_length();
      return (trig_len == 0) ? 1 : int'(trig_len);
    endfunction

    // Advance the predicted ranger by one accepted tick
    function void note_tick(logic echo);
      tick_result_t exp_r;
      int unsigned  range_val;
      int unsigned  div;
      exp_r     = '0;
      range_val = 0;
      case (phase)
        PH_WAIT: begin
          if (echo) begin
            phase    = PH_COUNT;
            echo_cnt = 16'd1;
          end
        end
        PH_COUNT: begin
          if (echo) begin
            if (echo_cnt != COUNT_SAT) echo_cnt = echo_cnt + 16'd1;
          end else begin
            exp_r.valid = 1'b1;
            readings++;
            if (echo_cnt >= limit) begin
              exp_r.oor = 1'b1;
              oor_readings++;
            end else begin
              div       = (cm_div == 0) ? 1 : int'(cm_div);
              range_val = int'(echo_cnt) / div;
            end
            phase    = PH_TRIGGER;
            trig_cnt = '0;
            echo_cnt = '0;
          end
        end
        default: begin
          exp_r.trig = 1'b1;
          trig_cnt   = trig_cnt + 8'd1;
          if (int'(trig_cnt) >= trigger_length()) begin
            trig_cnt = '0;
            phase    = PH_WAIT;
          end
        end
      endcase
      exp_r.range_cm = range_val[RANGE_W-1:0];
      exp_r.hund     = HUND_W'(range_val / 100);
      exp_r.tens     = DIGIT_W'((range_val / 10) % 10);
      exp_r.ones     = DIGIT_W'(range_val % 10);
      pending_q.push_back(exp_r);
      ticks++;
    endfunction

    task report(string msg);
      if (errors < 30) $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one output transfer with the oldest prediction
    task check_result(tick_result_t got);
      tick_result_t exp_r;
      if (pending_q.size() == 0) begin
        report("output transfer with no tick pending");
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.trig !== exp_r.trig)
        report($sformatf("trigger_out got %0b exp %0b", got.trig, exp_r.trig));
      if (got.valid !== exp_r.valid)
        report($sformatf("reading_valid got %0b exp %0b", got.valid, exp_r.valid));
      if (got.range_cm !== exp_r.range_cm)
        report($sformatf("range_cm got %0d exp %0d", got.range_cm, exp_r.range_cm));
      if (got.oor !== exp_r.oor)
        report($sformatf("out_of_range got %0b exp %0b", got.oor, exp_r.oor));
      if (got.hund !== exp_r.hund)
        report($sformatf("digit_hundreds got %0d exp %0d", got.hund, exp_r.hund));
      if (got.tens !== exp_r.tens)
        report($sformatf("digit_tens got %0d exp %0d", got.tens, exp_r.tens));
      if (got.ones !== exp_r.ones)
        report($sformatf("digit_ones got %0d exp %0d", got.ones, exp_r.ones));
      if (got.pad !== exp_r.pad)
        report($sformatf("tdata padding got %0h exp 0", got.pad));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;
  logic                 m_axis_tuser;

  range_scoreboard sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     cycles = 0;

  ultrasonic_echo_ranger dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, sb.pending_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sample output transfers and throttle tready
  always @(posedge clk_i) begin
    tick_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.trig     = m_axis_tdata[0];
      got.range_cm = m_axis_tdata[16:1];
      got.oor      = m_axis_tdata[17];
      got.hund     = m_axis_tdata[27:18];
      got.tens     = m_axis_tdata[31:28];
      got.ones     = m_axis_tdata[35:32];
      got.pad      = m_axis_tdata[39:36];
      got.valid    = m_axis_tuser;
      sb.check_result(got);
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Offer one tick and hold it until the transfer
  task send_tick(logic echo);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, echo};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_tick(echo);
  endtask

  // Drop the stream and wait for every pending result
  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers while the ranger is idle
  task configure(logic [CFG_W-1:0] trig, logic [CFG_W-1:0] maxc, logic [CFG_W-1:0] div);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_W-1:0]     val [3];
    idx = '{CFG_TRIGGER_TICKS, CFG_MAX_COUNT, CFG_TICKS_PER_CM};
    val = '{trig, maxc, div};
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    sb.settings++;
  endtask

  // One well-formed ping: trigger with random echo, a short wait, an echo pulse, the fall
  task ping(int unsigned n_high);
    int unsigned n_trig;
    n_trig = sb.trigger_length();
    repeat (n_trig) send_tick(1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 4)) send_tick(1'b0);
    repeat (n_high) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  function int unsigned pick_pulse();
    int unsigned n;
    if (sb.limit < 800 && $urandom_range(0, 99) < 15) begin
      n = int'(sb.limit) + $urandom_range(0, 2);
      n = (n > 1) ? n - 1 : 1;
    end else if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(41, 700);
    end else begin
      n = $urandom_range(1, 40);
    end
    return n;
  endfunction

  task random_segment(int unsigned mode);
    int unsigned start;
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
    start = sb.ticks;
    while (sb.ticks - start < SEG_TICKS) begin
      if ($urandom_range(0, 99) < 15) begin
        // noise: stray ticks, can break a ping in the middle
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
      end else begin
        ping(pick_pulse());
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: echo held high through the trigger is ignored, short pulse
    repeat (11) send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);

    // Zero trigger length and zero divisor act as one
    configure(16'd0, 16'd65535, 16'd0);
    send_tick(1'b0);
    repeat (5) send_tick(1'b1);
    send_tick(1'b0);

    // Zero limit puts every reading out of range
    configure(16'd1, 16'd0, 16'd1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);

    // Unit divisor with a pulse that fills all three digits
    configure(16'd1, 16'd65535, 16'd1);
    ping(321);

    // Random segments over several settings, extremes first
    for (int unsigned seg = 0; seg < 8; seg++) begin
      case (seg)
        0: configure(16'd1, 16'd65535, 16'd1);
        1: configure(16'd255, 16'd20, 16'd255);
        2: configure(16'd0, 16'd0, 16'd0);
        3: configure(16'($urandom_range(1, 8)), 16'($urandom_range(1, 400)),
                     16'($urandom_range(1, 20)));
        default: configure(16'($urandom_range(1, 8)),
                           ($urandom_range(0, 3) == 0) ? 16'd65535
                                                       : 16'($urandom_range(1, 600)),
                           16'($urandom_range(0, 255)));
      endcase
      random_segment(seg % 4);
    end

    // Let the last results come out
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d ticks, %0d readings (%0d out of range) over %0d register settings",
             sb.ticks, sb.readings, sb.oor_readings, sb.settings);
    $display("Mismatches: %0d, cycles: %0d", sb.errors, cycles);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ulr_pkg.sv
rtl/core/ulr_sdiv.sv
rtl/core/ultrasonic_echo_ranger.sv
tb/sv/tb.sv
